>>> rtl/lsds_pkg.sv
// Shared types and constants for the LIFO stack with duplicate and swap.
`default_nettype none

package lsds_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int WORD_W      = 32;

   localparam logic [2:0] ACT_PUSH  = 3'd0;
   localparam logic [2:0] ACT_POP   = 3'd1;
   localparam logic [2:0] ACT_PEEK  = 3'd2;
   localparam logic [2:0] ACT_DUP   = 3'd3;
   localparam logic [2:0] ACT_SWAP  = 3'd4;
   localparam logic [2:0] ACT_CLEAR = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

   typedef struct packed {
      logic [2:0]               action;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] data_out;
      logic [1:0]               status;
      logic [7:0]               depth;
   } rsp_type;

   // Broadcast to the cell row; only one bit is high, and only on a successful transaction.
   typedef struct packed {
      logic push;
      logic pop;
      logic dup;
      logic swap;
   } stack_cmd_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ABOVE,
      CELL_BELOW
   } cell_sel_type;

endpackage

`default_nettype wire

>>> rtl/lifo_stack_dup_swap.sv
// Top level of the LIFO stack with push, pop, peek, duplicate, swap and clear.
// Usage:
//   A request transaction on req_valid/req_ready carries an action and a push
//   value. Each request yields exactly one response transaction on
//   rsp_valid/rsp_ready with the popped or peeked word, a status and the depth.
//   The entries live in a row of cells; cell 0 is the top of the stack. Push
//   and duplicate shift the row down by one, pop shifts it up, swap exchanges
//   cells 0 and 1, all in the cycle of the transaction.
//   The response is registered and shows up the cycle after the request is
//   accepted. Throughput is one request per cycle while the receiver takes
//   responses.
//   When the receiver stalls, the response stays in its register and
//   req_ready drops until it is taken; it rises in the same cycle in which
//   rsp_ready drains the held response.
//   Reset empties the stack (count zero) and clears rsp_valid. The entry
//   words are not cleared; only entries written since are ever read.
`default_nettype none

module lifo_stack_dup_swap (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lsds_pkg::req_type req,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lsds_pkg::rsp_type      rsp
);

   lsds_pkg::stack_cmd_type            cmd;
   logic signed [lsds_pkg::WORD_W-1:0] words [lsds_pkg::STACK_DEPTH];

   lsds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .top_word  (words[0]),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   for (genvar i = 0; i < lsds_pkg::STACK_DEPTH; i++) begin : g_cell
      lsds_pkg::cell_sel_type             sel;
      logic signed [lsds_pkg::WORD_W-1:0] above;
      logic signed [lsds_pkg::WORD_W-1:0] below;

      if (i == 0) begin : g_top
         // The top takes the pushed word; on duplicate it keeps its own.
         assign above = req.push_value;
         always_comb begin
            priority if (cmd.push) begin
               sel = lsds_pkg::CELL_ABOVE;
            end else if (cmd.pop || cmd.swap) begin
               sel = lsds_pkg::CELL_BELOW;
            end else begin
               sel = lsds_pkg::CELL_HOLD;
            end
         end
      end else if (i == 1) begin : g_second
         assign above = words[i-1];
         always_comb begin
            priority if (cmd.push || cmd.dup || cmd.swap) begin
               sel = lsds_pkg::CELL_ABOVE;
            end else if (cmd.pop) begin
               sel = lsds_pkg::CELL_BELOW;
            end else begin
               sel = lsds_pkg::CELL_HOLD;
            end
         end
      end else begin : g_rest
         assign above = words[i-1];
         always_comb begin
            priority if (cmd.push || cmd.dup) begin
               sel = lsds_pkg::CELL_ABOVE;
            end else if (cmd.pop) begin
               sel = lsds_pkg::CELL_BELOW;
            end else begin
               sel = lsds_pkg::CELL_HOLD;
            end
         end
      end

      // The bottom cell has no neighbor below; what it loads on a pop is never read.
      if (i == lsds_pkg::STACK_DEPTH - 1) begin : g_bottom
         assign below = words[i];
      end else begin : g_inner
         assign below = words[i+1];
      end

      lsds_cell u_cell (
         .clock (clock),
         .sel   (sel),
         .above (above),
         .below (below),
         .word  (words[i])
      );
   end

endmodule

`default_nettype wire

>>> rtl/lsds_cell.sv
// One stack entry: holds a word or loads it from the neighbor above or below.
`default_nettype none

module lsds_cell (
   input  wire logic                              clock,
   input  wire lsds_pkg::cell_sel_type            sel,
   input  wire logic signed [lsds_pkg::WORD_W-1:0] above,
   input  wire logic signed [lsds_pkg::WORD_W-1:0] below,
   output logic signed [lsds_pkg::WORD_W-1:0]      word
);

   logic signed [lsds_pkg::WORD_W-1:0] word_ff;
   logic signed [lsds_pkg::WORD_W-1:0] word_in;

   always_comb begin
      unique case (sel)
         lsds_pkg::CELL_ABOVE: word_in = above;
         lsds_pkg::CELL_BELOW: word_in = below;
         default:              word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

`default_nettype wire

>>> rtl/lsds_ctrl.sv
// Action decode, entry count and the registered response for the stack.
`default_nettype none

module lsds_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire lsds_pkg::req_type                  req,
   input  wire logic signed [lsds_pkg::WORD_W-1:0] top_word,
   output lsds_pkg::stack_cmd_type                 cmd,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output lsds_pkg::rsp_type                       rsp
);

   localparam logic [lsds_pkg::COUNT_W-1:0] FULL_COUNT =
      lsds_pkg::COUNT_W'(lsds_pkg::STACK_DEPTH);
   localparam logic [lsds_pkg::COUNT_W-1:0] ONE = lsds_pkg::COUNT_W'(1);

   logic [lsds_pkg::COUNT_W-1:0] count_ff;
   logic [lsds_pkg::COUNT_W-1:0] count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   lsds_pkg::rsp_type            rsp_ff;
   lsds_pkg::rsp_type            rsp_in;
   logic                         fire;
   logic                         empty;
   logic                         full;
   logic                         below_two;

   // A new transaction may enter whenever the output register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign empty     = count_ff == '0;
   assign full      = count_ff == FULL_COUNT;
   assign below_two = count_ff < lsds_pkg::COUNT_W'(2);

   always_comb begin
      cmd             = '0;
      count_in        = count_ff;
      rsp_in.data_out = '0;
      rsp_in.status   = lsds_pkg::ST_OK;
      if (fire) begin
         unique case (req.action)
            lsds_pkg::ACT_PUSH: begin
               if (full) begin
                  rsp_in.status = lsds_pkg::ST_FULL;
               end else begin
                  cmd.push = 1'b1;
                  count_in = count_ff + ONE;
               end
            end
            lsds_pkg::ACT_POP: begin
               if (empty) begin
                  rsp_in.data_out = lsds_pkg::NEG_ONE;
                  rsp_in.status   = lsds_pkg::ST_EMPTY;
               end else begin
                  cmd.pop         = 1'b1;
                  rsp_in.data_out = top_word;
                  count_in        = count_ff - ONE;
               end
            end
            lsds_pkg::ACT_PEEK: begin
               if (empty) begin
                  rsp_in.data_out = lsds_pkg::NEG_ONE;
                  rsp_in.status   = lsds_pkg::ST_EMPTY;
               end else begin
                  rsp_in.data_out = top_word;
               end
            end
            lsds_pkg::ACT_DUP: begin
               if (empty) begin
                  rsp_in.data_out = lsds_pkg::NEG_ONE;
                  rsp_in.status   = lsds_pkg::ST_EMPTY;
               end else if (full) begin
                  rsp_in.status = lsds_pkg::ST_FULL;
               end else begin
                  cmd.dup  = 1'b1;
                  count_in = count_ff + ONE;
               end
            end
            lsds_pkg::ACT_SWAP: begin
               if (below_two) begin
                  rsp_in.data_out = lsds_pkg::NEG_ONE;
                  rsp_in.status   = lsds_pkg::ST_EMPTY;
               end else begin
                  cmd.swap = 1'b1;
               end
            end
            lsds_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
      rsp_in.depth = 8'(count_in);
   end

   always_comb begin
      if (req_ready) begin
         rsp_valid_in = req_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

>>> sim/tb_lifo_stack_dup_swap.sv
// Self-checking testbench for the LIFO stack with duplicate, swap and clear actions.
`default_nettype none

module tb_lifo_stack_dup_swap;
   timeunit 1ns;
   timeprecision 1ps;

   import lsds_pkg::*;

   // Action codes the block leaves undefined; they must not change the stack.
   localparam logic [2:0] ACT_UNDEF6 = 3'd6;
   localparam logic [2:0] ACT_UNDEF7 = 3'd7;

   localparam int RANDOM_ITEMS = 1750;
   localparam int PHASE_ITEMS  = 220;
   localparam int HOLD_AT      = 40;
   localparam int HOLD_CYCLES  = 80;
   localparam int MAX_GAP      = 30;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 30;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_type;

   // Predicts each response from its own copy of the stack and checks the
   // responses in order.
   class stack_scoreboard;
      logic signed [WORD_W-1:0] entries [STACK_DEPTH];
      int unsigned              count;
      rsp_type                  pending_rsp [$];
      int                       errors;
      int                       requests;
      int                       checked;
      int                       full_hits;
      int                       empty_hits;
      int                       peak_depth;

      task report(string msg);
         if (errors < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      function void note_request(req_type item);
         rsp_type want;
         logic signed [WORD_W-1:0] held;
         want.data_out = '0;
         want.status   = ST_OK;
         case (item.action)
            ACT_PUSH: begin
               if (count >= STACK_DEPTH) begin
                  want.status = ST_FULL;
               end else begin
                  entries[count] = item.push_value;
                  count++;
               end
            end
            ACT_POP, ACT_PEEK: begin
               if (count == 0) begin
                  want.data_out = NEG_ONE;
                  want.status   = ST_EMPTY;
               end else begin
                  want.data_out = entries[count - 1];
                  if (item.action == ACT_POP)
                     count--;
               end
            end
            ACT_DUP: begin
               if (count == 0) begin
                  want.data_out = NEG_ONE;
                  want.status   = ST_EMPTY;
               end else if (count >= STACK_DEPTH) begin
                  want.status = ST_FULL;
               end else begin
                  entries[count] = entries[count - 1];
                  count++;
               end
            end
            ACT_SWAP: begin
               if (count < 2) begin
                  want.data_out = NEG_ONE;
                  want.status   = ST_EMPTY;
               end else begin
                  held               = entries[count - 1];
                  entries[count - 1] = entries[count - 2];
                  entries[count - 2] = held;
               end
            end
            ACT_CLEAR: count = 0;
            default: ;
         endcase
         want.depth = 8'(count);
         if (want.status == ST_FULL)
            full_hits++;
         if (want.status == ST_EMPTY)
            empty_hits++;
         if (count > peak_depth)
            peak_depth = count;
         requests++;
         pending_rsp.push_back(want);
      endfunction

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            report($sformatf("response with no request outstanding: %h", got));
            return;
         end
         want = pending_rsp.pop_front();
         checked++;
         if (got.data_out !== want.data_out)
            report($sformatf("response %0d data_out %h, expected %h",
                             checked, got.data_out, want.data_out));
         if (got.status !== want.status)
            report($sformatf("response %0d status %0d, expected %0d",
                             checked, got.status, want.status));
         if (got.depth !== want.depth)
            report($sformatf("response %0d depth %0d, expected %0d",
                             checked, got.depth, want.depth));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp;

   logic    rx_hold;
   int      send_idle_pct;
   int      recv_stall_pct;
   int      cycle_count;

   stack_scoreboard stack_sb = new();

   lifo_stack_dup_swap i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Receiver: values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         stack_sb.check_response(rsp);
      if (reset || rx_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.",
                  cycle_count, stack_sb.pending_rsp.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request(mix_type mode);
      req_type     item;
      int unsigned roll;
      roll            = $urandom_range(99);
      item.push_value = random_word();
      case (mode)
         MODE_FILL:
            item.action = roll < 60 ? ACT_PUSH : roll < 85 ? ACT_DUP :
                          roll < 90 ? ACT_POP  : roll < 95 ? ACT_PEEK : ACT_SWAP;
         MODE_DRAIN:
            item.action = roll < 60 ? ACT_POP  : roll < 70 ? ACT_PEEK :
                          roll < 80 ? ACT_SWAP : roll < 95 ? ACT_PUSH : ACT_DUP;
         default:
            item.action = roll < 3  ? ACT_CLEAR  : roll < 5  ? ACT_UNDEF6 :
                          roll < 7  ? ACT_UNDEF7 : roll < 32 ? ACT_PUSH   :
                          roll < 52 ? ACT_POP    : roll < 67 ? ACT_PEEK   :
                          roll < 80 ? ACT_DUP    : ACT_SWAP;
      endcase
      return item;
   endfunction

   function automatic req_type make_request(logic [2:0] action, logic [WORD_W-1:0] value);
      req_type item;
      item.action     = action;
      item.push_value = value;
      return item;
   endfunction

   task automatic set_idling(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
         default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
   endtask

   // Offers one request and returns at the edge where the transaction happens.
   task automatic send_item(req_type item);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         req       <= req_type'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      do
         @(posedge clock);
      while (!req_ready);
      stack_sb.note_request(item);
   endtask

   initial begin
      mix_type mode;
      int      burst_left;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req            = '0;
      rx_hold        = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: underflow on an empty stack, extreme words, swap with one
      // entry, the undefined codes, and clear.
      send_item(make_request(ACT_POP,    32'h1234_5678));
      send_item(make_request(ACT_PEEK,   '0));
      send_item(make_request(ACT_DUP,    '0));
      send_item(make_request(ACT_SWAP,   '0));
      send_item(make_request(ACT_PUSH,   32'h7fff_ffff));
      send_item(make_request(ACT_SWAP,   '0));
      send_item(make_request(ACT_PEEK,   '0));
      send_item(make_request(ACT_PUSH,   32'h8000_0000));
      send_item(make_request(ACT_SWAP,   '0));
      send_item(make_request(ACT_PEEK,   '0));
      send_item(make_request(ACT_POP,    '0));
      send_item(make_request(ACT_DUP,    '1));
      send_item(make_request(ACT_PUSH,   '1));
      send_item(make_request(ACT_PUSH,   '0));
      send_item(make_request(ACT_PUSH,   32'ha5a5_a5a5));
      send_item(make_request(ACT_UNDEF6, 32'h5a5a_5a5a));
      send_item(make_request(ACT_UNDEF7, '1));
      send_item(make_request(ACT_SWAP,   '0));
      send_item(make_request(ACT_POP,    '0));
      send_item(make_request(ACT_POP,    '0));
      send_item(make_request(ACT_CLEAR,  '0));
      send_item(make_request(ACT_POP,    '0));
      send_item(make_request(ACT_PUSH,   32'h5a5a_5a5a));
      send_item(make_request(ACT_CLEAR,  '0));

      // Random bursts; the first one fills the stack so that refusals show up
      // early, later bursts pick a fill, drain or mixed flavor at random.
      mode       = MODE_FILL;
      burst_left = 160;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0)
            set_idling(n / PHASE_ITEMS);
         if (n == HOLD_AT) begin
            fork
               begin
                  rx_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rx_hold <= 1'b0;
               end
            join_none
         end
         if (burst_left == 0) begin
            mode       = mix_type'($urandom_range(2));
            burst_left = $urandom_range(20, 180);
         end
         burst_left--;
         send_item(random_request(mode));
      end
      req_valid <= 1'b0;

      while (stack_sb.pending_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Checked %0d responses for %0d requests; deepest stack %0d of %0d.",
               stack_sb.checked, stack_sb.requests, stack_sb.peak_depth, STACK_DEPTH);
      $display("Refused on full %0d times, underflow %0d times, %0d mismatches.",
               stack_sb.full_hits, stack_sb.empty_hits, stack_sb.errors);
      if (stack_sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
